>>> hdl/atli_pkg.sv
// Shared types and codes for the anchor table interpolator.
`timescale 1ns / 1ps
package atli_pkg;
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_DUP   = 2'd3;
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_QUERY  = 1'b1;
endpackage

>>> hdl/atli_ram.sv
// Generic single-port-write, single-read RAM with registered read.
`timescale 1ns / 1ps
module atli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> hdl/atli_div.sv
// Restoring 64-by-32 divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module atli_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);
  logic [63:0] num;
  logic [32:0] rem;
  logic [31:0] den;
  logic [6:0]  cnt;
  logic        busy;
  logic [32:0] trial;
  logic [32:0] shifted;

  assign shifted = {rem[31:0], num[63]};
  assign trial   = shifted - {1'b0, den};

  // Shift and subtract; quotient bits collect in num
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        num  <= dividend;
        den  <= divisor;
        rem  <= '0;
        cnt  <= 7'd0;
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial;
          num <= {num[62:0], 1'b1};
        end else begin
          rem <= shifted;
          num <= {num[62:0], 1'b0};
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  // Quotient fits in 32 bits since x-k0 < k1-k0
  assign quotient = num[31:0];
endmodule

>>> hdl/anchor_table_linear_interpolator_top.sv
// Top level of the anchor table linear interpolator.
`timescale 1ns / 1ps
// Usage: s_axis carries one item: tuser = action (0 insert, 1 query),
// tdata = {sample_time[63:32], ref_time[31:0]}. m_axis returns one result
// per item: tdata = {status[33:32], mapped_time[31:0]} padded to 40 bits.
// The block takes one item at a time; s_axis_tready is low while busy.
// An insert first walks the table from the top entry down without writing,
// to find a duplicate key or the free place, then walks down again moving
// each larger key up one place (one RAM read port).
// A query scans up from entry 0, reads the neighbors, multiplies once
// and runs a restoring divider; below the first key, or at or above the
// last key, it returns that end entry's value. The result register
// holds while m_axis_tready is low and the next item is accepted once
// the result is taken.
// Reset clears the anchor count and control; table contents need no clear.
module anchor_table_linear_interpolator_top #(
  parameter int MAX_ANCHORS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // ref_time[31:0], sample_time[63:32]
  input  logic        s_axis_tuser,  // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // mapped_time[31:0], status[33:32]
);
  localparam int AW = $clog2(MAX_ANCHORS);
  localparam int CW = $clog2(MAX_ANCHORS + 1);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_IRD   = 11'b00000000010,
    S_ICMP  = 11'b00000000100,
    S_QRD   = 11'b00000001000,
    S_QCMP  = 11'b00000010000,
    S_QLO   = 11'b00000100000,
    S_QLOW  = 11'b00001000000,
    S_QMUL  = 11'b00010000000,
    S_QDIV  = 11'b00100000000,
    S_QWAIT = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  state_t state;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic          scan;
  logic [31:0]   key, val;
  logic [31:0]   k1, v1, k0, v0;
  logic [63:0]   prod;
  logic [31:0]   mapped;
  logic [1:0]    status;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wkey, wval, rkey, rval;
  logic          div_start, div_done;
  logic [31:0]   quot;
  logic [31:0]   dv;

  atli_ram #(.WIDTH(32), .DEPTH(MAX_ANCHORS)) u_keys (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wkey), .raddr(raddr), .rdata(rkey));
  atli_ram #(.WIDTH(32), .DEPTH(MAX_ANCHORS)) u_vals (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wval), .raddr(raddr), .rdata(rval));
  atli_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(prod),
    .divisor(k1 - k0), .done(div_done), .quotient(quot));

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata  = {6'd0, status, mapped};
  assign dv            = (v1 >= v0) ? (v1 - v0) : (v0 - v1);
  assign div_start     = (state == S_QDIV);

  // Read address: insert walks down from idx-1, query walks up from idx
  always_comb begin
    raddr = idx[AW-1:0];
    if (state == S_IRD || state == S_ICMP) begin
      raddr = AW'(idx - CW'(1));
    end else if (state == S_QLO) begin
      raddr = AW'(idx - CW'(1));
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      we    <= 1'b0;
      state <= S_IDLE;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            key    <= s_axis_tdata[31:0];
            val    <= s_axis_tdata[63:32];
            mapped <= '0;
            status <= atli_pkg::ST_OK;
            scan   <= 1'b1;
            idx    <= (s_axis_tuser == atli_pkg::ACT_INSERT) ? count : '0;
            if (s_axis_tuser == atli_pkg::ACT_QUERY) begin
              if (count == '0) begin
                status <= atli_pkg::ST_EMPTY;
                state  <= S_OUT;
              end else begin
                state <= S_QRD;
              end
            end else begin
              // Duplicate check needs a scan; a full table is decided there too
              state <= (count == '0) ? S_ICMP : S_IRD;
            end
          end
        end
        S_IRD: begin
          we    <= 1'b0;
          state <= S_ICMP;
        end
        S_ICMP: begin
          // rkey = entry idx-1 (valid when idx > 0)
          if (idx != '0 && rkey > key) begin
            // Move the larger entry up one place on the second pass only
            we    <= !scan;
            waddr <= AW'(idx);
            wkey  <= rkey;
            wval  <= rval;
            idx   <= idx - CW'(1);
            state <= S_IRD;
          end else if (idx != '0 && rkey == key) begin
            // Duplicate found on the read-only pass: table untouched
            we     <= 1'b0;
            status <= atli_pkg::ST_DUP;
            state  <= S_OUT;
          end else if (count == CW'(MAX_ANCHORS)) begin
            we     <= 1'b0;
            status <= atli_pkg::ST_FULL;
            state  <= S_OUT;
          end else if (scan && idx != count) begin
            // No duplicate: restart from the top and shift this time
            we    <= 1'b0;
            scan  <= 1'b0;
            idx   <= count;
            state <= S_IRD;
          end else begin
            we    <= 1'b1;
            waddr <= AW'(idx);
            wkey  <= key;
            wval  <= val;
            count <= count + CW'(1);
            state <= S_OUT;
          end
        end
        S_QRD: state <= S_QCMP;
        S_QCMP: begin
          if (key < rkey) begin
            k1 <= rkey;
            v1 <= rval;
            if (idx == '0) begin
              mapped <= rval;
              state  <= S_OUT;
            end else begin
              state <= S_QLO;
            end
          end else if (idx == count - CW'(1)) begin
            mapped <= rval;
            state  <= S_OUT;
          end else begin
            idx   <= idx + CW'(1);
            state <= S_QRD;
          end
        end
        S_QLO: state <= S_QLOW;
        S_QLOW: begin
          k0    <= rkey;
          v0    <= rval;
          state <= S_QMUL;
        end
        S_QMUL: state <= S_QDIV;
        S_QDIV: begin
          state <= S_QWAIT;
        end
        S_QWAIT: begin
          if (div_done) begin
            mapped <= (v1 >= v0) ? (v0 + quot) : (v0 - quot);
            state  <= S_OUT;
          end
        end
        S_OUT: begin
          we <= 1'b0;
          if (m_axis_tready) state <= S_IDLE;
        end
        default: begin
          we    <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end
  // Product is registered in S_QMUL, the state before the divider start in S_QDIV
  always_ff @(posedge clk) begin
    if (state == S_QMUL) begin
      prod <= 64'(dv) * 64'(key - k0);
    end
  end
endmodule

>>> tb/anchor_table_linear_interpolator_top_tb.sv
// Self-checking testbench for the anchor table linear interpolator.
`timescale 1ns / 1ps
module anchor_table_linear_interpolator_top_tb;

  localparam int TBL_DEPTH  = 256;
  localparam int IDLE_LIMIT = 20000;
  localparam int LONG_HOLD  = 3000;

  typedef struct {
    logic        action;
    logic [31:0] ref_time;
    logic [31:0] sample_time;
  } anchor_req_t;

  typedef struct {
    logic [31:0] mapped_time;
    logic [1:0]  status;
  } anchor_resp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;   // ref_time[31:0], sample_time[63:32]
  logic        s_axis_tuser = 1'b0; // action
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // mapped_time[31:0], status[33:32]

  anchor_req_t  pending_q[$];
  anchor_resp_t mapped_q[$];
  logic [31:0]  gen_keys[$];

  // predictor copy of the anchor table
  logic [31:0] tbl_key[TBL_DEPTH];
  logic [31:0] tbl_val[TBL_DEPTH];
  int          tbl_cnt = 0;

  int  mismatches = 0;
  int  n_insert = 0, n_query = 0, n_full = 0, n_dup = 0, n_empty = 0, n_results = 0;
  int  idle_cycles = 0;
  int  send_gap = 0;
  int  hold_cnt = 0;
  bit  calm = 1'b0;
  bit  long_hold_done = 1'b0;
  int  accepted = 0;

  anchor_table_linear_interpolator_top uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Interpolate between the surrounding anchors, clamp outside the table.
  function automatic logic [31:0] map_time(logic [31:0] x);
    int i;
    logic [31:0] k0, k1, v0, v1;
    longint unsigned q;
    i = 0;
    while (i < tbl_cnt && !(x < tbl_key[i])) i++;
    if (i == 0) return tbl_val[0];
    if (i >= tbl_cnt) return tbl_val[tbl_cnt-1];
    k0 = tbl_key[i-1]; k1 = tbl_key[i];
    v0 = tbl_val[i-1]; v1 = tbl_val[i];
    if (v1 >= v0) begin
      q = (64'(v1 - v0) * 64'(x - k0)) / 64'(k1 - k0);
      return v0 + q[31:0];
    end
    q = (64'(v0 - v1) * 64'(x - k0)) / 64'(k1 - k0);
    return v0 - q[31:0];
  endfunction

  // Insert at the sorted place; duplicate check precedes full check.
  function automatic logic [1:0] add_anchor(logic [31:0] key, logic [31:0] val);
    int p;
    p = 0;
    while (p < tbl_cnt && tbl_key[p] < key) p++;
    if (p < tbl_cnt && tbl_key[p] == key) return atli_pkg::ST_DUP;
    if (tbl_cnt >= TBL_DEPTH) return atli_pkg::ST_FULL;
    for (int j = tbl_cnt; j > p; j--) begin
      tbl_key[j] = tbl_key[j-1];
      tbl_val[j] = tbl_val[j-1];
    end
    tbl_key[p] = key;
    tbl_val[p] = val;
    tbl_cnt++;
    return atli_pkg::ST_OK;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  // Driver: advance to the next pending item once the current one is taken.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (send_gap > 0 || pending_q.size() == 0) begin
        if (send_gap > 0) send_gap <= send_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else begin
        anchor_req_t it;
        it = pending_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.action;
        s_axis_tdata  <= {it.sample_time, it.ref_time};
        send_gap <= gap_len();
      end
    end
  end

  // Receiver: random stalls, one long hold-off partway through the run.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      m_axis_tready <= 1'b0;
    end else if (!long_hold_done && accepted >= 800) begin
      long_hold_done <= 1'b1;
      hold_cnt <= LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 99) < 2) begin
      hold_cnt <= $urandom_range(20, 60);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(0, 99) >= 20);
    end
  end

  // Predict on each accepted item.
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      anchor_resp_t e;
      accepted <= accepted + 1;
      e.mapped_time = '0;
      if (s_axis_tuser == atli_pkg::ACT_INSERT) begin
        n_insert++;
        e.status = add_anchor(s_axis_tdata[31:0], s_axis_tdata[63:32]);
      end else if (tbl_cnt == 0) begin
        n_query++;
        e.status = atli_pkg::ST_EMPTY;
      end else begin
        n_query++;
        e.mapped_time = map_time(s_axis_tdata[31:0]);
        e.status = atli_pkg::ST_OK;
      end
      mapped_q.insert(mapped_q.size(), e);
    end
  end

  // Check each result against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (mapped_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: mapped=%h status=%0d",
                   m_axis_tdata[31:0], m_axis_tdata[33:32]);
      end else begin
        anchor_resp_t e;
        e = mapped_q.pop_front();
        if (m_axis_tdata[31:0] !== e.mapped_time || m_axis_tdata[33:32] !== e.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch #%0d: exp mapped=%h status=%0d, got mapped=%h status=%0d",
                     n_results, e.mapped_time, e.status,
                     m_axis_tdata[31:0], m_axis_tdata[33:32]);
        end else begin
          if (e.status == atli_pkg::ST_FULL) n_full++;
          if (e.status == atli_pkg::ST_DUP) n_dup++;
          if (e.status == atli_pkg::ST_EMPTY) n_empty++;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either side.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
      $display("[anchor_table_linear_interpolator_top] ERROR");
      $finish;
    end
  end

  task automatic push_item(logic action, logic [31:0] rt, logic [31:0] st);
    anchor_req_t it;
    it.action = action;
    it.ref_time = rt;
    it.sample_time = st;
    pending_q.insert(pending_q.size(), it);
    if (action == atli_pkg::ACT_INSERT) gen_keys.insert(gen_keys.size(), rt);
  endtask

  // Random query point: extremes, exact keys, near keys, or anywhere.
  function automatic logic [31:0] pick_point();
    int r;
    logic [31:0] k;
    r = $urandom_range(0, 99);
    k = gen_keys.size() ? gen_keys[$urandom_range(0, gen_keys.size()-1)] : $urandom;
    if (r < 5) return 32'h0;
    if (r < 10) return 32'hFFFF_FFFF;
    if (r < 30) return k;
    if (r < 50) return k + $urandom_range(1, 255);
    return $urandom;
  endfunction

  initial begin
    logic [31:0] k;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, single anchor, extremes, duplicates
    push_item(atli_pkg::ACT_QUERY,  32'h0001_0000, 32'hFFFF_FFFF);
    push_item(atli_pkg::ACT_INSERT, 32'h0010_0000, 32'h0005_0000);
    push_item(atli_pkg::ACT_QUERY,  32'h0000_0000, 32'h0);
    push_item(atli_pkg::ACT_QUERY,  32'h0010_0000, 32'h0);
    push_item(atli_pkg::ACT_QUERY,  32'hFFFF_FFFF, 32'h0);
    push_item(atli_pkg::ACT_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
    push_item(atli_pkg::ACT_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
    push_item(atli_pkg::ACT_INSERT, 32'h0010_0000, 32'h1234_5678);
    push_item(atli_pkg::ACT_INSERT, 32'h0020_0000, 32'hFFFF_FFFF);
    push_item(atli_pkg::ACT_QUERY,  32'h0000_0000, 32'h0);
    push_item(atli_pkg::ACT_QUERY,  32'h0000_0001, 32'h0);
    push_item(atli_pkg::ACT_QUERY,  32'h0008_0000, 32'hFFFF_FFFF);
    push_item(atli_pkg::ACT_QUERY,  32'h0018_0000, 32'h0);
    push_item(atli_pkg::ACT_QUERY,  32'h001F_FFFF, 32'h0);
    push_item(atli_pkg::ACT_QUERY,  32'h0020_0000, 32'h0);
    push_item(atli_pkg::ACT_QUERY,  32'h8000_0000, 32'h0);
    push_item(atli_pkg::ACT_QUERY,  32'hFFFF_FFFE, 32'h0);
    push_item(atli_pkg::ACT_QUERY,  32'hFFFF_FFFF, 32'h0);
    push_item(atli_pkg::ACT_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // random: mostly queries, slow table growth, some duplicate keys
    for (int n = 0; n < 1380; n++) begin
      int r;
      r = $urandom_range(0, 99);
      if (n % 200 == 0) calm = ($urandom_range(0, 2) == 0);
      if (r < 7)
        push_item(atli_pkg::ACT_INSERT, $urandom, $urandom);
      else if (r < 9)
        push_item(atli_pkg::ACT_INSERT, gen_keys[$urandom_range(0, gen_keys.size()-1)],
                  $urandom);
      else
        push_item(atli_pkg::ACT_QUERY, pick_point(), $urandom);
      while (pending_q.size() > 8) @(posedge clk);
    end
    calm = 1'b0;

    // fill the table, then hit it with new keys, duplicates and queries
    for (int n = 0; n < 300; n++) begin
      if (n % 10 == 9) push_item(atli_pkg::ACT_QUERY, pick_point(), $urandom);
      else push_item(atli_pkg::ACT_INSERT, $urandom, $urandom);
      while (pending_q.size() > 8) @(posedge clk);
    end
    for (int n = 0; n < 30; n++) begin
      k = gen_keys[$urandom_range(0, gen_keys.size()-1)];
      case (n % 3)
        0: push_item(atli_pkg::ACT_INSERT, $urandom, $urandom);
        1: push_item(atli_pkg::ACT_INSERT, k, $urandom);
        default: push_item(atli_pkg::ACT_QUERY, pick_point(), $urandom);
      endcase
      while (pending_q.size() > 8) @(posedge clk);
    end

    // drain
    while (pending_q.size() > 0 || s_axis_tvalid || mapped_q.size() > 0) @(posedge clk);
    repeat (700) @(posedge clk);

    $display("covered %0d inserts and %0d queries; final table holds %0d anchors",
             n_insert, n_query, tbl_cnt);
    $display("status seen: %0d empty, %0d duplicate, %0d full; %0d mismatches",
             n_empty, n_dup, n_full, mismatches);
    if (mismatches == 0 && mapped_q.size() == 0)
      $display("[anchor_table_linear_interpolator_top] OK");
    else
      $display("[anchor_table_linear_interpolator_top] ERROR");
    $finish;
  end
endmodule
